// ----- rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and codes of the generational handle allocator: command and
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int CMD_W       = 2;
  localparam int WORD_W      = 32;
  localparam int CFG_W       = 11;
  localparam int STATUS_W    = 2;
  localparam int NEW_INDEX_W = 10;
  localparam int SLOTS_RESET = 1024;

  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_STALE   = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_POP
  } state_t;

  typedef struct packed {
    logic capture;
    logic pop_read;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_pop;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ----- rtl/gha_ctrl.sv -----
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer of the handle allocator: takes an item, waits for the memory
// reads, runs the second read of a reused slot and commits the result.
// ----------------------------------------------------------------------------
module gha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gha_pkg::ctrl_stat_t st,
  output gha_pkg::ctrl_cmd_t  ctl
);
  import gha_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    ctl.capture  = 1'b0;
    ctl.pop_read = 1'b0;
    ctl.commit   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        if (st.need_pop) begin
          ctl.pop_read = 1'b1;
          state_next   = S_POP;
        end else if (st.out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (st.out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> st.out_free)
    else $error("commit while result register is full");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.capture, ctl.pop_read, ctl.commit}))
    else $error("more than one datapath command");

  a_pop_needed: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> st.need_pop)
    else $error("slot reuse step without a queued slot");

endmodule

// ----- rtl/gha_datapath.sv -----
// ----------------------------------------------------------------------------
// gha_datapath
// Generation, live and freed-slot memories, ring pointers, fill mark,
// slot count register and the result register of the handle allocator.
// ----------------------------------------------------------------------------
module gha_datapath #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  gha_pkg::ctrl_cmd_t              ctl,
  output gha_pkg::ctrl_stat_t             st,
  input  logic                            cfg_we,
  input  logic [gha_pkg::CFG_W-1:0]       cfg_data,
  input  logic [gha_pkg::CMD_W-1:0]       cmd,
  input  logic [gha_pkg::WORD_W-1:0]      handle_index,
  input  logic [gha_pkg::WORD_W-1:0]      handle_generation,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gha_pkg::STATUS_W-1:0]    status,
  output logic [gha_pkg::NEW_INDEX_W-1:0] new_index,
  output logic [gha_pkg::WORD_W-1:0]      new_generation,
  output logic                            is_live
);
  import gha_pkg::*;

  localparam int IW    = $clog2(MAX_SLOTS);
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int DEPTH = 1 << IW;
  localparam logic [CW-1:0] CAP_RESET =
    CW'((MAX_SLOTS < SLOTS_RESET) ? MAX_SLOTS : SLOTS_RESET);
  localparam logic [CW-1:0] CAP_MAX   = CW'(MAX_SLOTS);

  logic [WORD_W-1:0] gen_mem  [DEPTH];
  logic              live_mem [DEPTH];
  logic [IW-1:0]     ring_mem [DEPTH];

  logic [CW-1:0]     cap;
  logic [CW-1:0]     cap_next;
  logic [IW-1:0]     ring_head;
  logic [IW-1:0]     ring_tail;
  logic [CW-1:0]     ring_count;
  logic [CW-1:0]     fresh_next;

  logic [CMD_W-1:0]  cmd_r;
  logic [WORD_W-1:0] hidx_r;
  logic [WORD_W-1:0] hgen_r;
  logic [IW-1:0]     ring_q;
  logic [WORD_W-1:0] gen_q;
  logic              live_q;
  logic              filled_q;

  logic [IW-1:0]     rd_addr;
  logic              rd_filled;

  logic [WORD_W-1:0] gen_cur;
  logic              live_cur;
  logic              handle_ok;
  logic              handle_hit;
  logic              do_pop;
  logic              do_fresh;
  logic              do_free;
  logic [IW-1:0]     slot;
  logic [CW-1:0]     head_inc;
  logic [CW-1:0]     tail_inc;

  logic [STATUS_W-1:0] status_d;
  logic [WORD_W-1:0]   ngen_d;
  logic                live_d;

  logic                gen_we;
  logic [IW-1:0]       gen_waddr;
  logic [WORD_W-1:0]   gen_wdata;
  logic                live_we;
  logic [IW-1:0]       live_waddr;
  logic                live_wdata;

  // slot count clamp
  always_comb begin
    if (cfg_data == '0) begin
      cap_next = CW'(1);
    end else if (32'(cfg_data) > 32'(MAX_SLOTS)) begin
      cap_next = CAP_MAX;
    end else begin
      cap_next = CW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cap_next;
    end
  end

  // read side
  always_comb begin
    if (ctl.pop_read) begin
      rd_addr   = ring_q;
      rd_filled = CW'(ring_q) < fresh_next;
    end else begin
      rd_addr   = handle_index[IW-1:0];
      rd_filled = handle_index < 32'(fresh_next);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= cmd;
      hidx_r <= handle_index;
      hgen_r <= handle_generation;
      ring_q <= ring_mem[ring_head];
    end
    if (ctl.capture || ctl.pop_read) begin
      gen_q    <= gen_mem[rd_addr];
      live_q   <= live_mem[rd_addr];
      filled_q <= rd_filled;
    end
  end

  // entries at or above the fill mark read as generation zero and not live
  assign gen_cur    = filled_q ? gen_q : '0;
  assign live_cur   = filled_q & live_q;
  assign handle_ok  = (hidx_r != '1) && (hgen_r != '1);
  assign handle_hit = handle_ok && (hidx_r < 32'(cap)) && live_cur && (gen_cur == hgen_r);

  assign st.need_pop = (cmd_r == CMD_CREATE) && (ring_count != '0);
  assign st.out_free = !out_valid || out_ready;

  always_comb begin
    status_d = STATUS_OK;
    ngen_d   = '0;
    live_d   = 1'b0;
    slot     = '0;
    do_pop   = 1'b0;
    do_fresh = 1'b0;
    do_free  = 1'b0;
    case (cmd_r)
      CMD_CREATE: begin
        if (ring_count != '0) begin
          slot   = ring_q;
          ngen_d = gen_cur;
          do_pop = 1'b1;
        end else if (fresh_next < cap) begin
          slot     = fresh_next[IW-1:0];
          do_fresh = 1'b1;
        end else begin
          status_d = STATUS_FULL;
        end
      end
      CMD_DESTROY: begin
        if (!handle_ok) begin
          status_d = STATUS_INVALID;
        end else if (!handle_hit) begin
          status_d = STATUS_STALE;
        end else begin
          do_free = 1'b1;
        end
      end
      CMD_QUERY: begin
        live_d = handle_hit;
      end
      default: begin
        status_d = STATUS_INVALID;
      end
    endcase
  end

  // memory write ports
  always_comb begin
    gen_we     = ctl.commit && (do_fresh || do_free);
    gen_waddr  = do_free ? hidx_r[IW-1:0] : slot;
    gen_wdata  = do_free ? gen_cur + 32'd1 : '0;
    live_we    = ctl.commit && (do_pop || do_fresh || do_free);
    live_waddr = do_free ? hidx_r[IW-1:0] : slot;
    live_wdata = !do_free;
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (live_we) begin
      live_mem[live_waddr] <= live_wdata;
    end
    if (ctl.commit && do_free) begin
      ring_mem[ring_tail] <= hidx_r[IW-1:0];
    end
  end

  // ring pointers and fill mark
  assign head_inc = CW'(ring_head) + CW'(1);
  assign tail_inc = CW'(ring_tail) + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_head  <= '0;
      ring_tail  <= '0;
      ring_count <= '0;
      fresh_next <= '0;
    end else if (ctl.commit) begin
      if (do_pop) begin
        ring_head  <= (head_inc >= cap) ? '0 : head_inc[IW-1:0];
        ring_count <= ring_count - CW'(1);
      end
      if (do_fresh) begin
        fresh_next <= fresh_next + CW'(1);
      end
      if (do_free) begin
        ring_tail <= (tail_inc >= cap) ? '0 : tail_inc[IW-1:0];
        if (ring_count < CAP_MAX) begin
          ring_count <= ring_count + CW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status         <= status_d;
      new_index      <= NEW_INDEX_W'(slot);
      new_generation <= ngen_d;
      is_live        <= live_d;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CAP_MAX)
    else $error("freed slot count above capacity");

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= CAP_MAX)
    else $error("fill mark above capacity");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> out_valid)
    else $error("committed item not presented");

endmodule

// ----- rtl/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot map that hands out handles of a slot index and a 32-bit generation,
// reusing freed slots in FIFO order.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle. Every item but a create
// that reuses a freed slot reads the generation and live memories at the
// accepting edge and is committed to the result register from the read
// state; a create that reuses a freed slot passes through the pop state
// first, since the generation read follows the read of the freed-slot ring.
// The next item is accepted in the cycle after the commit, so the block
// takes no new item before the last one is committed. The result sits
// in an output register, so the next item is taken while it waits; only a
// commit waits for that register to be free. Reset takes effect at once:
// slots at or above the fill mark read as generation zero and not live, so
// no clearing pass is run. The slot count register is written through the
// cfg channel, which is always ready.
module generational_handle_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gha_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gha_pkg::CMD_W-1:0]       cmd,
  input  logic [gha_pkg::WORD_W-1:0]      handle_index,
  input  logic [gha_pkg::WORD_W-1:0]      handle_generation,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gha_pkg::STATUS_W-1:0]    status,
  output logic [gha_pkg::NEW_INDEX_W-1:0] new_index,
  output logic [gha_pkg::WORD_W-1:0]      new_generation,
  output logic                            is_live
);
  import gha_pkg::*;

  ctrl_cmd_t  ctl;
  ctrl_stat_t st;

  assign cfg_ready = 1'b1;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  gha_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .st                (st),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .new_index         (new_index),
    .new_generation    (new_generation),
    .is_live           (is_live)
  );

endmodule
